/* sv/jsu_pkg.sv */
// Shared types for the JSON string unescaper: decode phases, result kinds,
// error codes and the per-byte result bundle passed from front to back.
// No dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEXH    = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_HEXL    = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE         = 3'd0,
        ERR_CONTROL      = 3'd1,
        ERR_BAD_ESCAPE   = 3'd2,
        ERR_BAD_HEX      = 3'd3,
        ERR_LONE_LOW     = 3'd4,
        ERR_UNPAIRED     = 3'd5,
        ERR_NUL          = 3'd6,
        ERR_UNTERMINATED = 3'd7
    } err_t;

    // All results caused by one input byte: data bytes, then an optional status.
    typedef struct packed {
        logic [2:0]      n_data;
        logic [3:0][7:0] data;
        logic            has_status;
        kind_t           kind;
        err_t            err;
    } jsu_run_t;

endpackage

/* sv/jsu_front.sv */
// Front end: accepts string bytes, runs the escape/surrogate decoder and
// builds one result bundle per byte. Depends on jsu_pkg.
module jsu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_starts_string,
    input  logic [7:0]        s_in_byte,
    input  logic              s_text_ends,
    input  logic              q_full,
    output logic              push,
    output jsu_pkg::jsu_run_t push_run
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // {invalid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b0, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b0, 4'(b - 8'h37)};
        return r;
    endfunction

    function automatic logic [34:0] utf8_encode(input logic [20:0] c);
        logic [2:0]      n;
        logic [3:0][7:0] d;
        d = '0;
        if (c < 21'h80) begin
            n = 3'd1;
            d[0] = c[7:0];
        end else if (c < 21'h800) begin
            n = 3'd2;
            d[0] = {3'b110, c[10:6]};
            d[1] = {2'b10, c[5:0]};
        end else if (c < 21'h10000) begin
            n = 3'd3;
            d[0] = {4'b1110, c[15:12]};
            d[1] = {2'b10, c[11:6]};
            d[2] = {2'b10, c[5:0]};
        end else begin
            n = 3'd4;
            d[0] = {5'b11110, c[20:18]};
            d[1] = {2'b10, c[17:12]};
            d[2] = {2'b10, c[11:6]};
            d[3] = {2'b10, c[5:0]};
        end
        return {n, d};
    endfunction

    logic            check_only_reg;
    phase_t          phase_reg, phase_next, phase_eff;
    logic [1:0]      cnt_reg, cnt_next, cnt_eff;
    logic [11:0]     acc_reg, acc_next, acc_eff;
    logic [9:0]      hi_reg, hi_next;

    logic            accept;
    logic [4:0]      hv;
    logic [15:0]     code16;
    logic [20:0]     cp;
    logic            do_enc;
    logic [34:0]     enc;
    logic [2:0]      nd;
    logic [3:0][7:0] data;
    logic            active;
    logic            has_status;
    kind_t           kind;
    err_t            err;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign phase_eff = s_starts_string ? PH_BODY : phase_reg;
    assign cnt_eff   = s_starts_string ? 2'd0 : cnt_reg;
    assign acc_eff   = s_starts_string ? 12'd0 : acc_reg;
    assign hv        = hex_value(s_in_byte);
    assign code16    = {acc_eff, hv[3:0]};

    always_comb begin
        cnt_next   = cnt_eff;
        acc_next   = acc_eff;
        hi_next    = hi_reg;
        nd         = 3'd0;
        data       = '0;
        active     = 1'b1;
        has_status = 1'b0;
        kind       = KIND_DATA;
        err        = ERR_NONE;
        cp         = {5'd0, code16};
        do_enc     = 1'b0;
        case (phase_eff)
            PH_BODY: begin
                if (s_in_byte == CH_QUOTE) begin
                    has_status = 1'b1;
                    kind = KIND_DONE;
                end else if (s_in_byte < 8'h20) begin
                    has_status = 1'b1;
                    kind = KIND_ERROR;
                    err = ERR_CONTROL;
                end else if (s_in_byte != CH_BSL) begin
                    nd = 3'd1;
                    data[0] = s_in_byte;
                end
            end
            PH_ESC: begin
                nd = 3'd1;
                case (s_in_byte)
                    CH_QUOTE: data[0] = CH_QUOTE;
                    CH_BSL:   data[0] = CH_BSL;
                    CH_SLASH: data[0] = CH_SLASH;
                    CH_B:     data[0] = 8'h08;
                    CH_F:     data[0] = 8'h0c;
                    CH_N:     data[0] = 8'h0a;
                    CH_R:     data[0] = 8'h0d;
                    CH_T:     data[0] = 8'h09;
                    CH_U: begin
                        nd = 3'd0;
                        cnt_next = 2'd0;
                        acc_next = 12'd0;
                    end
                    default: begin
                        nd = 3'd0;
                        has_status = 1'b1;
                        kind = KIND_ERROR;
                        err = ERR_BAD_ESCAPE;
                    end
                endcase
            end
            PH_HEXH, PH_HEXL: begin
                if (hv[4]) begin
                    has_status = 1'b1;
                    kind = KIND_ERROR;
                    err = ERR_BAD_HEX;
                end else if (cnt_eff != 2'd3) begin
                    acc_next = {acc_eff[7:0], hv[3:0]};
                    cnt_next = cnt_eff + 2'd1;
                end else begin
                    cnt_next = 2'd0;
                    acc_next = 12'd0;
                    if (phase_eff == PH_HEXH) begin
                        if (code16[15:10] == 6'b110110) begin
                            hi_next = code16[9:0];
                        end else if (code16[15:10] == 6'b110111) begin
                            has_status = 1'b1;
                            kind = KIND_ERROR;
                            err = ERR_LONE_LOW;
                        end else if (code16 == 16'd0) begin
                            has_status = 1'b1;
                            kind = KIND_ERROR;
                            err = ERR_NUL;
                        end else begin
                            do_enc = 1'b1;
                        end
                    end else begin
                        if (code16[15:10] == 6'b110111) begin
                            cp = {11'({1'b0, hi_reg}) + 11'd64, code16[9:0]};
                            do_enc = 1'b1;
                        end else begin
                            has_status = 1'b1;
                            kind = KIND_ERROR;
                            err = ERR_UNPAIRED;
                        end
                    end
                end
            end
            PH_WANT_BS: begin
                if (s_in_byte != CH_BSL) begin
                    has_status = 1'b1;
                    kind = KIND_ERROR;
                    err = ERR_UNPAIRED;
                end
            end
            PH_WANT_U: begin
                if (s_in_byte == CH_U) begin
                    cnt_next = 2'd0;
                    acc_next = 12'd0;
                end else begin
                    has_status = 1'b1;
                    kind = KIND_ERROR;
                    err = ERR_UNPAIRED;
                end
            end
            default: begin
                active = 1'b0;
            end
        endcase
        enc = utf8_encode(cp);
        if (do_enc) begin
            nd = enc[34:32];
            data = enc[31:0];
        end
        if (active && !has_status && s_text_ends) begin
            has_status = 1'b1;
            kind = KIND_ERROR;
            err = ERR_UNTERMINATED;
            nd = 3'd0;
        end
        if (has_status) begin
            cnt_next = 2'd0;
        end
        if (check_only_reg) begin
            nd = 3'd0;
        end
    end

    always_comb begin
        phase_next = phase_eff;
        if (has_status) begin
            phase_next = PH_IDLE;
        end else begin
            case (phase_eff)
                PH_BODY: begin
                    if (s_in_byte == CH_BSL) phase_next = PH_ESC;
                end
                PH_ESC: begin
                    phase_next = (s_in_byte == CH_U) ? PH_HEXH : PH_BODY;
                end
                PH_HEXH: begin
                    if (cnt_eff == 2'd3) begin
                        phase_next = (code16[15:10] == 6'b110110) ? PH_WANT_BS : PH_BODY;
                    end
                end
                PH_WANT_BS: begin
                    phase_next = PH_WANT_U;
                end
                PH_WANT_U: begin
                    phase_next = PH_HEXL;
                end
                PH_HEXL: begin
                    if (cnt_eff == 2'd3) phase_next = PH_BODY;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        push_run.n_data     = nd;
        push_run.data       = data;
        push_run.has_status = has_status;
        push_run.kind       = kind;
        push_run.err        = err;
        push = accept && (has_status || nd != 3'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_only_reg <= 1'b0;
            phase_reg      <= PH_IDLE;
            cnt_reg        <= 2'd0;
            acc_reg        <= 12'd0;
            hi_reg         <= 10'd0;
        end else begin
            if (cfg_wr_en) begin
                check_only_reg <= cfg_wr_data;
            end
            if (accept) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
                hi_reg    <= hi_next;
            end
        end
    end

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_full)
        else $error("front pushed into a full queue");

    a_status_ends_string: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && has_status) |=> phase_reg == PH_IDLE)
        else $error("decoder not idle after done or error");

    a_check_only_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && check_only_reg) |-> push_run.n_data == 3'd0)
        else $error("data request built in check-only mode");

endmodule

/* sv/jsu_queue.sv */
// Short register queue carrying result bundles from front to back.
// Generic width and depth; no package dependency.
module jsu_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + CW'(1);
        else if (pop && !push) count_next = count_reg - CW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

endmodule

/* sv/jsu_back.sv */
// Back end: walks the queue's head bundle one result per cycle, unless m_ready stalls,
// into the output register, popping it after its last result. Depends on jsu_pkg.
module jsu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  jsu_pkg::jsu_run_t q_head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic [1:0]        m_kind,
    output logic [2:0]        m_error_code,
    output logic              m_last_of_run
);
    import jsu_pkg::*;

    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    kind_t      kind_reg, kind_next;
    err_t       err_reg, err_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg;
    logic [2:0] total;
    logic       load;

    assign load  = q_not_empty && (!valid_reg || m_ready);
    assign total = q_head.n_data + {2'd0, q_head.has_status};

    always_comb begin
        last_next = ({1'b0, idx_reg} + 3'd1) == total;
        if ({1'b0, idx_reg} < q_head.n_data) begin
            byte_next = q_head.data[idx_reg];
            kind_next = KIND_DATA;
            err_next  = ERR_NONE;
        end else begin
            byte_next = 8'd0;
            kind_next = q_head.kind;
            err_next  = q_head.err;
        end
        pop = load && last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= last_next ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            kind_reg <= kind_next;
            err_reg  <= err_next;
            last_reg <= last_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_kind        = kind_reg;
    assign m_error_code  = err_reg;
    assign m_last_of_run = last_reg;

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_DATA) |-> m_last_of_run)
        else $error("status result not last of its run");

    a_data_no_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_DATA) |-> m_error_code == ERR_NONE)
        else $error("data result carries an error code");

    a_idx_reset_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> idx_reg == 2'd0)
        else $error("result index not rewound after pop");

endmodule

/* sv/json_string_unescape_utf8.sv */
// Top level of the JSON string unescaper with UTF-8 encoding.
// Instantiates jsu_front, jsu_queue and jsu_back; depends on jsu_pkg.
//
//   channel | ports                         | direction | per request
//   s_      | s_valid/s_ready + 3 fields    | in        | one string byte
//   m_      | m_valid/m_ready + 4 fields    | out       | one result (data/done/error)
//   cfg_    | cfg_wr_en, cfg_wr_data        | in        | check_only write
//
// One input byte is taken per cycle while the queue is not full; a byte that yields n
// results gives n output results in order, data bytes first, then any status.
// The decoder is combinational on the input; results cross a QUEUE_DEPTH-entry
// bundle queue to the output register, so input stalls only when it is full.
// Reset (aresetn low, synchronous) empties the queue and returns to idle.
module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_starts_string,
    input  logic [7:0] s_in_byte,
    input  logic       s_text_ends,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic [2:0] m_error_code,
    output logic       m_last_of_run
);
    import jsu_pkg::*;

    localparam int RW = $bits(jsu_run_t);

    logic     q_full, q_not_empty, push, pop;
    jsu_run_t push_run, head_run;
    logic [RW-1:0] head_bits;

    assign head_run = jsu_run_t'(head_bits);

    jsu_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_starts_string (s_starts_string),
        .s_in_byte       (s_in_byte),
        .s_text_ends     (s_text_ends),
        .q_full          (q_full),
        .push            (push),
        .push_run        (push_run)
    );

    jsu_queue #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (RW'(push_run)),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head      (head_bits)
    );

    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head        (head_run),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_kind        (m_kind),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

endmodule
